/* src/assert_macros.svh */
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// expression must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

/* src/irclt_pkg.sv */
// types, character codes and command check helpers for the irc line tokenizer
`default_nettype none

package irclt_pkg;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [2:0] DIGIT_CMD_LEN = 3'd3;
  localparam logic [2:0] CMD_LEN_SAT = 3'd4;

  typedef enum logic [2:0] {
    ROLE_SEP      = 3'd0,
    ROLE_PREFIX   = 3'd1,
    ROLE_COMMAND  = 3'd2,
    ROLE_MIDDLE   = 3'd3,
    ROLE_TRAILING = 3'd4
  } role_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_ALPHA = 2'd1,
    CMD_DIGIT = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [2:0] len;
    logic       bad;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    role_e      role;
    logic       token_first;
    logic [7:0] param_number;
    logic       line_done;
    logic       line_valid;
    logic       prefix_seen;
    logic [7:0] param_total;
    logic       param_overflow;
  } result_t;

  function automatic logic is_letter(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_lower(logic [7:0] b);
    return b >= 8'h61 && b <= 8'h7A;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  // one command byte: classify on the first byte, then check the rest
  function automatic cmd_t cmd_feed(cmd_t c, logic [7:0] b);
    cmd_t r;
    r = c;
    if (c.len == 3'd0) begin
      if (is_letter(b)) begin
        r.kind = CMD_ALPHA;
      end else if (is_digit(b)) begin
        r.kind = CMD_DIGIT;
      end else begin
        r.bad = 1'b1;
      end
    end else begin
      case (c.kind)
        CMD_ALPHA: if (!is_letter(b)) r.bad = 1'b1;
        CMD_DIGIT: if (!is_digit(b)) r.bad = 1'b1;
        default:   r.bad = 1'b1;
      endcase
    end
    if (c.len < CMD_LEN_SAT) begin
      r.len = c.len + 3'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/irclt_core.sv */
// line state registers and per-byte tagging logic of the irc line tokenizer
`default_nettype none

module irclt_core #(
  parameter int COUNT_BITS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              last_i,
  output irclt_pkg::result_t     res_o
);

  logic                  any_q, any_d;
  logic                  in_tok_q, in_tok_d;
  logic                  in_trail_q, in_trail_d;
  irclt_pkg::role_e      role_q, role_d;
  logic                  prefix_q, prefix_d;
  logic                  started_q, started_d;
  irclt_pkg::cmd_t       cmd_q, cmd_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  ovf_q, ovf_d;

  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  ovf_inc;
  logic [COUNT_BITS-1:0] pnum;
  irclt_pkg::role_e      role;
  logic                  first;
  logic                  valid;

  // saturating parameter counter
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_BITS'(1);
  assign ovf_inc = ovf_q | (cnt_q == '1);

  always_comb begin
    any_d      = any_q;
    in_tok_d   = in_tok_q;
    in_trail_d = in_trail_q;
    role_d     = role_q;
    prefix_d   = prefix_q;
    started_d  = started_q;
    cmd_d      = cmd_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    role       = irclt_pkg::ROLE_SEP;
    first      = 1'b0;
    pnum       = '0;

    if (in_trail_q || (in_tok_q && byte_i != irclt_pkg::CH_SPACE)) begin
      // continuing the current token
      role = role_q;
      if (role_q == irclt_pkg::ROLE_COMMAND) begin
        cmd_d = irclt_pkg::cmd_feed(cmd_q, byte_i);
      end
      if (role_q == irclt_pkg::ROLE_MIDDLE || role_q == irclt_pkg::ROLE_TRAILING) begin
        pnum = cnt_q;
      end
    end else if (byte_i == irclt_pkg::CH_SPACE) begin
      in_tok_d = 1'b0;
    end else begin
      first = 1'b1;
      if (!any_q) begin
        if (byte_i == irclt_pkg::CH_COLON) begin
          prefix_d = 1'b1;
          role_d   = irclt_pkg::ROLE_PREFIX;
        end else begin
          started_d = 1'b1;
          role_d    = irclt_pkg::ROLE_COMMAND;
          cmd_d     = irclt_pkg::cmd_feed(cmd_q, byte_i);
        end
        role = role_d;
      end else if (byte_i == irclt_pkg::CH_COLON) begin
        // trailing token, colon itself is dropped
        in_trail_d = 1'b1;
        if (!started_q) begin
          started_d = 1'b1;
          role_d    = irclt_pkg::ROLE_COMMAND;
        end else begin
          cnt_d  = cnt_inc;
          ovf_d  = ovf_inc;
          role_d = irclt_pkg::ROLE_TRAILING;
          pnum   = cnt_inc;
        end
        role = irclt_pkg::ROLE_SEP;
      end else begin
        if (!started_q) begin
          started_d = 1'b1;
          role_d    = irclt_pkg::ROLE_COMMAND;
          cmd_d     = irclt_pkg::cmd_feed(cmd_q, byte_i);
        end else begin
          cnt_d  = cnt_inc;
          ovf_d  = ovf_inc;
          role_d = irclt_pkg::ROLE_MIDDLE;
          pnum   = cnt_inc;
        end
        role = role_d;
      end
      any_d    = 1'b1;
      in_tok_d = 1'b1;
    end
  end

  assign valid = started_d && !cmd_d.bad && (cmd_d.len != 3'd0) &&
                 (cmd_d.kind == irclt_pkg::CMD_ALPHA ||
                  (cmd_d.kind == irclt_pkg::CMD_DIGIT &&
                   cmd_d.len == irclt_pkg::DIGIT_CMD_LEN));

  always_comb begin
    res_o              = '0;
    res_o.out_byte     = byte_i;
    if (role == irclt_pkg::ROLE_COMMAND && cmd_d.kind == irclt_pkg::CMD_ALPHA &&
        irclt_pkg::is_lower(byte_i)) begin
      res_o.out_byte = byte_i - irclt_pkg::CASE_OFFSET;
    end
    res_o.role         = role;
    res_o.token_first  = first;
    res_o.param_number = 8'(pnum);
    res_o.line_done    = last_i;
    if (last_i) begin
      res_o.line_valid     = valid;
      res_o.prefix_seen    = prefix_d;
      res_o.param_total    = 8'(cnt_d);
      res_o.param_overflow = ovf_d;
    end
  end

  // line state, cleared after the final byte of a line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q      <= 1'b0;
      in_tok_q   <= 1'b0;
      in_trail_q <= 1'b0;
      role_q     <= irclt_pkg::ROLE_SEP;
      prefix_q   <= 1'b0;
      started_q  <= 1'b0;
      cmd_q      <= '{kind: irclt_pkg::CMD_NONE, len: 3'd0, bad: 1'b0};
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        any_q      <= 1'b0;
        in_tok_q   <= 1'b0;
        in_trail_q <= 1'b0;
        role_q     <= irclt_pkg::ROLE_SEP;
        prefix_q   <= 1'b0;
        started_q  <= 1'b0;
        cmd_q      <= '{kind: irclt_pkg::CMD_NONE, len: 3'd0, bad: 1'b0};
        cnt_q      <= '0;
        ovf_q      <= 1'b0;
      end else begin
        any_q      <= any_d;
        in_tok_q   <= in_tok_d;
        in_trail_q <= in_trail_d;
        role_q     <= role_d;
        prefix_q   <= prefix_d;
        started_q  <= started_d;
        cmd_q      <= cmd_d;
        cnt_q      <= cnt_d;
        ovf_q      <= ovf_d;
      end
    end
  end

endmodule

`default_nettype wire

/* src/irc_line_tokenizer.sv */
// irc line tokenizer top level: input register, tagging core, result register
//
// Takes one IRC message line (CR LF removed) one byte per transaction and
// returns one tagged byte per transaction: the byte itself (command letters
// uppercased), its role (separator or dropped colon, prefix, command, middle
// or trailing parameter), a token-start flag and the parameter index. The
// transaction carrying the final byte (tlast) also reports whether the
// command is valid (all letters, or exactly three digits), whether a prefix
// was seen, and the saturating parameter count with its overflow flag.
// Throughput is one byte per clock cycle while m_axis_tready does not stall
// the pipeline; a byte passes the input register and the core into the
// result register, which offers it. The per-byte state update is a loop
// inside the core; the input register stalls only while it is full and the
// result register is held by a deasserted m_axis_tready.
`default_nettype none
`include "assert_macros.svh"

module irc_line_tokenizer #(
  parameter int COUNT_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,   // line_end
  // result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] out_byte, [10:8] role, [11] token_first, [19:12] param_number,
  // [20] line_valid, [21] prefix_seen, [29:22] param_total,
  // [30] param_overflow, [31] zero
  output      logic [31:0] m_axis_tdata,
  output      logic        m_axis_tlast    // line_done
);

  // input register
  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               in_last_q;

  // result register
  logic               out_valid_q;
  irclt_pkg::result_t out_res_q;
  irclt_pkg::result_t core_res;

  logic advance;

  // the pipeline moves whenever the result register is free or being drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // state is committed only when the tagged byte moves into the result register
  irclt_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_valid_q && advance),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_res_q.line_done;
  assign m_axis_tdata  = {1'b0,
                          out_res_q.param_overflow,
                          out_res_q.param_total,
                          out_res_q.prefix_seen,
                          out_res_q.line_valid,
                          out_res_q.param_number,
                          out_res_q.token_first,
                          out_res_q.role,
                          out_res_q.out_byte};

  // line summary fields are only populated on the final byte
  `ASSERT_CLK(a_summary_only_at_end, clk_i, rst_ni,
    (out_valid_q && !out_res_q.line_done) |->
      (out_res_q.param_total == 8'd0 && !out_res_q.line_valid &&
       !out_res_q.prefix_seen && !out_res_q.param_overflow))

  // only parameter bytes and the colon opening a trailing parameter carry an index
  `ASSERT_CLK(a_pnum_only_in_params, clk_i, rst_ni,
    (out_valid_q && (out_res_q.role == irclt_pkg::ROLE_PREFIX ||
                     out_res_q.role == irclt_pkg::ROLE_COMMAND ||
                     (out_res_q.role == irclt_pkg::ROLE_SEP &&
                      !out_res_q.token_first))) |->
      (out_res_q.param_number == 8'd0))

  // input side stalls only behind a full, blocked pipeline
  `ASSERT_NEVER(a_no_needless_stall, clk_i, rst_ni,
    !s_axis_tready && !(in_valid_q && out_valid_q && !m_axis_tready))

endmodule

`default_nettype wire
